// ----- rtl/core/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Operation codes, status codes and fixed port widths of the double-ended
// queue core.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Fixed widths of the item fields
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

endpackage

// ----- rtl/core/dq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed words in a ring buffer. Each input
// word asks for push front, push back, pop front or pop back and yields one
// result word with the new end words, the occupancy and a status.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  kind, value
//   output   out        out_valid/out_ready  front_word, back_word,
//                                            occupancy, is_empty, status
//
// An operation passes the execute state (pointer update, slot RAM write or
// address) and the done state (RAM read of the new end word after a pop).
// The front and back words are cached in registers, so pushes need no read.
// A new word is taken in the cycle a result is loaded into the output
// register; a stalled output holds the finished operation until it drains.
// Reset clears pointers and count; the slot RAM is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dq_pkg::KIND_W-1:0]          kind,
  input  logic signed [dq_pkg::DATA_W-1:0]   value,
  // output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dq_pkg::DATA_W-1:0]   front_word,
  output logic signed [dq_pkg::DATA_W-1:0]   back_word,
  output logic [dq_pkg::OCC_W-1:0]           occupancy,
  output logic                               is_empty,
  output logic [dq_pkg::STATUS_W-1:0]        status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state;
  logic [1:0]                        state_next;
  logic [AW-1:0]                     head;
  logic [AW-1:0]                     tail;
  logic [CW-1:0]                     count;
  logic [WORD_WIDTH-1:0]             front_reg;
  logic [WORD_WIDTH-1:0]             back_reg;
  logic [dq_pkg::KIND_W-1:0]         kind_q;
  logic [WORD_WIDTH-1:0]             value_q;
  logic [dq_pkg::STATUS_W-1:0]       op_status;
  logic                              pend_front;
  logic                              pend_back;

  logic                              in_fire;
  logic                              out_free;
  logic                              is_push;
  logic                              is_front;
  logic                              full;
  logic                              empty;
  logic [AW-1:0]                     head_inc;
  logic [AW-1:0]                     head_dec;
  logic [AW-1:0]                     tail_inc;
  logic [AW-1:0]                     tail_dec;
  logic [AW-1:0]                     tail_dec2;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic                              ram_re;
  logic [AW-1:0]                     ram_raddr;
  logic [WORD_WIDTH-1:0]             ram_rdata;
  logic [WORD_WIDTH-1:0]             front_fin;
  logic [WORD_WIDTH-1:0]             back_fin;

  // Handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign in_fire  = in_valid && in_ready;

  // Ring pointer neighbors
  assign head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec  = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc  = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec  = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign tail_dec2 = (tail_dec == '0) ? LAST_IDX : tail_dec - 1'b1;

  // Operation decode
  assign is_push  = (kind_q == dq_pkg::KIND_PUSH_FRONT) ||
                    (kind_q == dq_pkg::KIND_PUSH_BACK);
  assign is_front = (kind_q == dq_pkg::KIND_PUSH_FRONT) ||
                    (kind_q == dq_pkg::KIND_POP_FRONT);
  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);

  // RAM access in the execute cycle: write on a non-full push, read the new
  // end on a pop leaving words behind. Reads and writes never share a cycle.
  assign ram_we    = (state == S_EXEC) && is_push && !full;
  assign ram_waddr = is_front ? head_dec : tail;
  assign ram_re    = (state == S_EXEC) && !is_push && (count > CW'(1));
  assign ram_raddr = is_front ? head_inc : tail_dec2;

  dq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // End words after the operation
  assign front_fin = pend_front ? ram_rdata : front_reg;
  assign back_fin  = pend_back  ? ram_rdata : back_reg;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (in_fire) begin
          state_next = S_EXEC;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      pend_front <= 1'b0;
      pend_back  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        pend_front <= ram_re && is_front;
        pend_back  <= ram_re && !is_front;
        if (is_push && !full) begin
          count <= count + 1'b1;
          if (is_front) head <= head_dec;
          else          tail <= tail_inc;
        end else if (!is_push && !empty) begin
          count <= count - 1'b1;
          if (is_front) head <= head_inc;
          else          tail <= tail_dec;
        end
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured input word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q  <= kind;
      value_q <= WORD_WIDTH'($unsigned(value));
    end
  end

  // Cached end words and status
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      if (is_push) begin
        op_status <= full ? dq_pkg::STATUS_PUSH_FULL : dq_pkg::STATUS_DONE;
      end else begin
        op_status <= empty ? dq_pkg::STATUS_POP_EMPTY : dq_pkg::STATUS_DONE;
      end
      if (is_push && !full) begin
        if (is_front || empty) front_reg <= value_q;
        if (!is_front || empty) back_reg <= value_q;
      end
    end
    if (state == S_DONE) begin
      front_reg <= front_fin;
      back_reg  <= back_fin;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      front_word <= empty ? '1 : dq_pkg::DATA_W'($signed(front_fin));
      back_word  <= empty ? '1 : dq_pkg::DATA_W'($signed(back_fin));
      occupancy  <= dq_pkg::OCC_W'(count);
      is_empty   <= empty;
      status     <= op_status;
    end
  end

`ifndef SYNTHESIS
  // Count never passes the ring size
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("occupancy count above depth");

  // Empty or full ring has coinciding pointers, otherwise they differ
  assert property (@(posedge clk) disable iff (rst)
    (head == tail) == ((count == '0) || (count == FULL_CNT)))
    else $error("ring pointers disagree with count");

  // A rejected pop reports an empty queue with both words at -1
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == dq_pkg::STATUS_POP_EMPTY)) |->
      (is_empty && (front_word == '1) && (back_word == '1)))
    else $error("pop on empty reported wrong words");

  // No word is taken while an operation is executing
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> !in_ready)
    else $error("input taken during execute");
`endif

endmodule
